/* hw/rtl/pra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pra_pkg;

   // ring of kept rates
   localparam int AVG_DEPTH = 4;
   localparam int RATE_W    = 8;
   localparam int SLOT_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int FILL_W    = $clog2(AVG_DEPTH + 1);
   localparam int SUM_W     = RATE_W + FILL_W;

   // input and register fields
   localparam int IR_W   = 18;
   localparam int TIME_W = 32;

   // beat interval window, ms
   localparam int MIN_INTERVAL_MS = 245;
   localparam int MAX_INTERVAL_MS = 1999;
   localparam int MS_PER_MINUTE   = 60000;
   localparam int THRESHOLD_RESET = 50000;

   // shared bit-serial divider
   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 11;
   localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_result_type;

endpackage
`default_nettype wire

/* hw/rtl/pra_serial_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module pra_serial_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [pra_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [pra_pkg::DIVISOR_W-1:0]  divisor,
   output pra_pkg::div_result_type             result
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [pra_pkg::DIV_CNT_W-1:0]  count_ff, count_in;
   logic [pra_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [pra_pkg::DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [pra_pkg::DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [pra_pkg::DIVISOR_W:0]    shifted;
   logic [pra_pkg::DIVISOR_W:0]    diff;
   logic                           fits;

   // restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      shifted = {rem_ff, quo_ff[pra_pkg::DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});

      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;

      if (start) begin
         busy_in  = 1'b1;
         count_in = pra_pkg::DIV_CNT_W'(pra_pkg::DIVIDEND_W - 1);
         quo_in   = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[pra_pkg::DIVIDEND_W-2:0], fits};
         rem_in   = fits ? diff[pra_pkg::DIVISOR_W-1:0] : shifted[pra_pkg::DIVISOR_W-1:0];
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign result = {done_ff, quo_ff};

endmodule
`default_nettype wire

/* hw/rtl/pulse_rate_averager.sv */
`timescale 1ns / 1ps
`default_nettype none
// Pulse rate averager. Each req word is one optical sample (IR level, beat flag, ms time);
// each gives exactly one rsp word with status, rolling average bpm and the finger flag.
// A sample with no beat, or with the first beat after a clear, goes from acceptance
// through an evaluate step to a finish step that loads the rsp register; a later beat
// passes a check step, and one whose interval falls outside 245..1999 ms then goes to
// the finish step. A kept beat computes the rate 60000/interval and then the average
// sum/fill; both go through one shared bit-serial divider that produces one quotient
// bit per cycle and then flags completion.
// One sample is worked on at a time; a finished result waits in the rsp register while the
// next sample is already taken, and that sample holds in its last step until the rsp
// register is free. Register 0 (sensor_online) and 1 (finger_threshold) are to be written
// through the csr channel only while idle; the block itself does not enforce it.
module pulse_rate_averager (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [55:0] req_tdata,   // ir_level[17:0], now_ms[49:18], zero pad
   input  wire logic        req_tuser,   // beat_seen
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // avg_bpm[7:0], finger_present[8], zero pad
   output logic [1:0]       rsp_tuser,   // status
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [17:0] csr_data
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EVAL    = 3'd1;
   localparam logic [2:0] S_CHECK   = 3'd2;
   localparam logic [2:0] S_DIV_BPM = 3'd3;
   localparam logic [2:0] S_SUM     = 3'd4;
   localparam logic [2:0] S_DIV_AVG = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   localparam logic [1:0] STATUS_OFFLINE     = 2'd0;
   localparam logic [1:0] STATUS_NO_FINGER   = 2'd1;
   localparam logic [1:0] STATUS_CALIBRATING = 2'd2;
   localparam logic [1:0] STATUS_VALID       = 2'd3;

   localparam logic CSR_SENSOR_ONLINE    = 1'b0;
   localparam logic CSR_FINGER_THRESHOLD = 1'b1;

   logic [2:0] state_ff, state_in;

   logic                           online_ff, online_in;
   logic [pra_pkg::IR_W-1:0]       thr_ff, thr_in;

   logic [pra_pkg::IR_W-1:0]       ir_ff, ir_in;
   logic                           beat_ff, beat_in;
   logic [pra_pkg::TIME_W-1:0]     now_ff, now_in;
   logic [pra_pkg::TIME_W-1:0]     interval_ff, interval_in;

   logic [pra_pkg::RATE_W-1:0]     ring_ff [pra_pkg::AVG_DEPTH];
   logic [pra_pkg::RATE_W-1:0]     ring_in [pra_pkg::AVG_DEPTH];
   logic [pra_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [pra_pkg::FILL_W-1:0]     fill_ff, fill_in;
   logic [pra_pkg::TIME_W-1:0]     last_ff, last_in;
   logic                           beat_valid_ff, beat_valid_in;
   logic [pra_pkg::RATE_W-1:0]     average_ff, average_in;
   logic                           finger_ff, finger_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [1:0]                     rsp_status_ff, rsp_status_in;
   logic [pra_pkg::RATE_W-1:0]     rsp_avg_ff, rsp_avg_in;
   logic                           rsp_finger_ff, rsp_finger_in;

   logic [pra_pkg::SUM_W-1:0]      ring_sum;
   logic                           div_start;
   logic [pra_pkg::DIVIDEND_W-1:0] div_dividend;
   logic [pra_pkg::DIVISOR_W-1:0]  div_divisor;
   pra_pkg::div_result_type        div_result;

   pra_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .result   (div_result)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      ring_sum = '0;
      for (int k = 0; k < pra_pkg::AVG_DEPTH; k++) begin
         ring_sum = ring_sum + pra_pkg::SUM_W'(ring_ff[k]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      online_in     = online_ff;
      thr_in        = thr_ff;
      ir_in         = ir_ff;
      beat_in       = beat_ff;
      now_in        = now_ff;
      interval_in   = interval_ff;
      ring_in       = ring_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      beat_valid_in = beat_valid_ff;
      average_in    = average_ff;
      finger_in     = finger_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_avg_in    = rsp_avg_ff;
      rsp_finger_in = rsp_finger_ff;
      div_start     = 1'b0;
      div_dividend  = pra_pkg::DIVIDEND_W'(pra_pkg::MS_PER_MINUTE);
      div_divisor   = interval_ff[pra_pkg::DIVISOR_W-1:0];

      if (csr_valid) begin
         case (csr_index)
            CSR_SENSOR_ONLINE:    online_in = csr_data[0];
            CSR_FINGER_THRESHOLD: thr_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               ir_in    = req_tdata[17:0];
               now_in   = req_tdata[49:18];
               beat_in  = req_tuser;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in = S_FINISH;
            if (!online_ff || (ir_ff < thr_ff)) begin
               finger_in = 1'b0;
               for (int k = 0; k < pra_pkg::AVG_DEPTH; k++) begin
                  ring_in[k] = '0;
               end
               slot_in       = '0;
               fill_in       = '0;
               last_in       = '0;
               beat_valid_in = 1'b0;
               average_in    = '0;
            end else begin
               finger_in = 1'b1;
               if (beat_ff) begin
                  last_in = now_ff;
                  if (!beat_valid_ff) begin
                     beat_valid_in = 1'b1;
                  end else begin
                     interval_in = now_ff - last_ff;
                     state_in    = S_CHECK;
                  end
               end
            end
         end
         S_CHECK: begin
            if ((interval_ff >= pra_pkg::TIME_W'(pra_pkg::MIN_INTERVAL_MS)) &&
                (interval_ff <= pra_pkg::TIME_W'(pra_pkg::MAX_INTERVAL_MS))) begin
               div_start = 1'b1;
               state_in  = S_DIV_BPM;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV_BPM: begin
            if (div_result.done) begin
               ring_in[slot_ff] = div_result.quotient[pra_pkg::RATE_W-1:0];
               slot_in = (slot_ff == pra_pkg::SLOT_W'(pra_pkg::AVG_DEPTH - 1)) ?
                         '0 : slot_ff + 1'b1;
               if (fill_ff < pra_pkg::FILL_W'(pra_pkg::AVG_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            // entries past the fill count are still zero, so the whole ring sums
            div_start    = 1'b1;
            div_dividend = pra_pkg::DIVIDEND_W'(ring_sum);
            div_divisor  = pra_pkg::DIVISOR_W'(fill_ff);
            state_in     = S_DIV_AVG;
         end
         S_DIV_AVG: begin
            if (div_result.done) begin
               average_in = div_result.quotient[pra_pkg::RATE_W-1:0];
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_avg_in    = average_ff;
               rsp_finger_in = finger_ff;
               if (!online_ff) begin
                  rsp_status_in = STATUS_OFFLINE;
               end else if (!finger_ff) begin
                  rsp_status_in = STATUS_NO_FINGER;
               end else if (average_ff == '0) begin
                  rsp_status_in = STATUS_CALIBRATING;
               end else begin
                  rsp_status_in = STATUS_VALID;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         online_ff     <= 1'b1;
         thr_ff        <= pra_pkg::IR_W'(pra_pkg::THRESHOLD_RESET);
         for (int k = 0; k < pra_pkg::AVG_DEPTH; k++) begin
            ring_ff[k] <= '0;
         end
         slot_ff       <= '0;
         fill_ff       <= '0;
         last_ff       <= '0;
         beat_valid_ff <= 1'b0;
         average_ff    <= '0;
         finger_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         online_ff     <= online_in;
         thr_ff        <= thr_in;
         ring_ff       <= ring_in;
         slot_ff       <= slot_in;
         fill_ff       <= fill_in;
         last_ff       <= last_in;
         beat_valid_ff <= beat_valid_in;
         average_ff    <= average_in;
         finger_ff     <= finger_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ir_ff         <= ir_in;
      beat_ff       <= beat_in;
      now_ff        <= now_in;
      interval_ff   <= interval_in;
      rsp_status_ff <= rsp_status_in;
      rsp_avg_ff    <= rsp_avg_in;
      rsp_finger_ff <= rsp_finger_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {7'd0, rsp_finger_ff, rsp_avg_ff};

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= pra_pkg::FILL_W'(pra_pkg::AVG_DEPTH))
      else $error("fill count beyond ring depth");

   a_slot_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff < pra_pkg::FILL_W'(pra_pkg::AVG_DEPTH)) |->
      (pra_pkg::FILL_W'(slot_ff) == fill_ff))
      else $error("write slot out of step with fill count");

   a_avg_needs_fill: assert property (@(posedge clock) disable iff (reset)
      (average_ff != '0) |-> (fill_ff != '0) && finger_ff)
      else $error("average held with empty ring");

   a_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_VALID) |->
      rsp_finger_ff && (rsp_avg_ff != '0))
      else $error("valid status without finger or average");

endmodule
`default_nettype wire
